### rtl/lsbm_pkg.sv
package lsbm_pkg;

  // LED count and widths
  localparam int NUM_LEDS    = 4;
  localparam int LED_IDX_W   = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int ASSIGN_W    = 8;
  localparam int CODE_W      = 7;
  localparam int PERIOD_W    = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_PERIOD = 3'd4;

  // Reset value of the blink period
  localparam logic [PERIOD_W-1:0] DEFAULT_BLINK_PERIOD = 16'd500;
  localparam logic [PERIOD_W-1:0] TICK_MAX             = 16'hFFFF;

  // Action and drive codes
  localparam logic [1:0] ACT_OFF     = 2'd0;
  localparam logic [1:0] ACT_STEADY  = 2'd1;
  localparam logic [1:0] ACT_ONESHOT = 2'd2;
  localparam logic [1:0] ACT_NONE    = 2'd3;

  // Input function codes
  localparam logic FUNC_PUBLISH = 1'b0;
  localparam logic FUNC_TICK    = 1'b1;

  typedef struct packed {
    logic              func;
    logic [CODE_W-1:0] stimulus;
    logic [1:0]        action;
  } in_word_t;

  typedef struct packed {
    logic [LED_IDX_W-1:0] led_index;
    logic [1:0]           led_state;
    logic                 last;
  } out_word_t;

  // Command broadcast to every cell while a word is scanned
  typedef struct packed {
    logic              publish;   // publish word with a valid action
    logic              step;      // tick word that steps the blink phase
    logic              phase;     // phase after the step
    logic [CODE_W-1:0] code;
    logic [1:0]        act;
  } cmd_t;

  // Result offered by the cell that holds the token
  typedef struct packed {
    logic                 valid;
    logic [LED_IDX_W-1:0] led_index;
    logic [1:0]           led_state;
    logic                 last;
  } res_t;

endpackage

### rtl/lsbm_cell.sv
module lsbm_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [lsbm_pkg::LED_IDX_W-1:0]      idx,
  input  lsbm_pkg::cmd_t                      cmd,
  input  logic                                adv,
  input  logic                                tok_in,
  input  logic                                later_in,
  input  logic                                cfg_we,
  input  logic [lsbm_pkg::ASSIGN_W-1:0]       cfg_assign,
  output logic                                tok_out,
  output logic                                later_out,
  output lsbm_pkg::res_t                      res
);
  import lsbm_pkg::*;

  logic [ASSIGN_W-1:0] assign_r;
  logic [1:0]          drive_r, drive_nxt;
  logic [1:0]          trigger_r, trigger_nxt;
  logic                tok_r;
  logic                match;
  logic [1:0]          want;
  logic                change;
  logic [1:0]          new_state;

  // Work out this LED's response to the current command
  assign match = (assign_r[CODE_W-1:0] == cmd.code);
  assign want  = {1'b0, assign_r[ASSIGN_W-1]} ^ cmd.act;

  always_comb begin
    change      = 1'b0;
    new_state   = ACT_OFF;
    drive_nxt   = drive_r;
    trigger_nxt = trigger_r;
    if (cmd.publish) begin
      new_state = want;
      if (match) begin
        trigger_nxt = cmd.act;
        if (drive_r != ACT_ONESHOT && cmd.act != ACT_ONESHOT && want != drive_r) begin
          change    = 1'b1;
          drive_nxt = want;
        end
      end
    end else if (cmd.step) begin
      if (cmd.phase) begin
        new_state = ACT_ONESHOT;
        if (trigger_r == ACT_ONESHOT) begin
          change      = 1'b1;
          drive_nxt   = ACT_ONESHOT;
          trigger_nxt = ACT_OFF;
        end
      end else if (drive_r == ACT_ONESHOT) begin
        change    = 1'b1;
        drive_nxt = ACT_OFF;
      end
    end
  end

  // Tell upstream cells whether a change follows them
  assign later_out = change | later_in;
  assign tok_out   = tok_r;

  assign res.valid     = tok_r & change;
  assign res.led_index = tok_r ? idx : '0;
  assign res.led_state = tok_r ? new_state : ACT_OFF;
  assign res.last      = tok_r & ~later_in;

  // Hold state; update it as the token passes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      assign_r  <= '0;
      drive_r   <= ACT_OFF;
      trigger_r <= ACT_OFF;
      tok_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        assign_r <= cfg_assign;
      end
      if (adv) begin
        tok_r <= tok_in;
        if (tok_r) begin
          drive_r   <= drive_nxt;
          trigger_r <= trigger_nxt;
        end
      end
    end
  end

endmodule

### rtl/led_stimulus_blink_manager_core.sv
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid/in_ready   | in_data   (func, stimulus, action)
// out     | output    | out_valid/out_ready | out_data  (led_index, led_state, last)
// cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// An accepted word sends a token down the row of LED cells, one cell a cycle
// unless the output stalls; no new word is taken until the token leaves the last cell.
// Each change leaves through a one-word output register; a stalled output
// freezes the token. Reset is synchronous: all LEDs off, no triggers,
// phase zero, blink period 500. Configuration is always ready.
module led_stimulus_blink_manager_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  lsbm_pkg::in_word_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output lsbm_pkg::out_word_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lsbm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lsbm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lsbm_pkg::*;

  logic                 busy_r;
  logic                 start_r;
  cmd_t                 cmd_r, cmd_nxt;
  logic                 phase_r;
  logic                 blinked_r;
  logic [PERIOD_W-1:0]  cnt_r;
  logic [PERIOD_W-1:0]  cnt_inc;
  logic [PERIOD_W-1:0]  period_r;
  logic                 step;
  logic                 in_acc, cfg_acc, adv;
  logic                 out_valid_r;
  out_word_t            out_data_r;

  logic [NUM_LEDS-1:0]  tok;
  logic [NUM_LEDS:0]    later;
  res_t                 res   [NUM_LEDS];
  res_t                 res_any;

  assign in_ready  = ~busy_r;
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid & in_ready;
  assign cfg_acc   = cfg_valid & cfg_ready;
  assign adv       = ~out_valid_r | out_ready;

  // Decide whether this tick steps the blink phase
  assign cnt_inc = (cnt_r == TICK_MAX) ? TICK_MAX : cnt_r + 16'd1;
  assign step    = ~blinked_r | (cnt_inc >= period_r);

  always_comb begin
    cmd_nxt.publish = (in_data.func == FUNC_PUBLISH) && (in_data.action != ACT_NONE);
    cmd_nxt.step    = (in_data.func == FUNC_TICK) && step;
    cmd_nxt.phase   = ~phase_r;
    cmd_nxt.code    = in_data.stimulus;
    cmd_nxt.act     = in_data.action;
  end

  // Sequence the scan and keep the tick timer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      start_r   <= 1'b0;
      cmd_r     <= '0;
      phase_r   <= 1'b0;
      blinked_r <= 1'b0;
      cnt_r     <= '0;
      period_r  <= DEFAULT_BLINK_PERIOD;
    end else begin
      if (cfg_acc && cfg_index == REG_BLINK_PERIOD) begin
        period_r <= cfg_data;
      end
      if (in_acc) begin
        busy_r  <= 1'b1;
        start_r <= 1'b1;
        cmd_r   <= cmd_nxt;
        if (in_data.func == FUNC_TICK) begin
          if (step) begin
            cnt_r     <= '0;
            blinked_r <= 1'b1;
            phase_r   <= ~phase_r;
          end else begin
            cnt_r <= cnt_inc;
          end
        end
      end else if (adv) begin
        start_r <= 1'b0;
        if (tok[NUM_LEDS-1]) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Row of LED cells
  assign later[NUM_LEDS] = 1'b0;

  for (genvar g = 0; g < NUM_LEDS; g++) begin : g_cell
    logic tok_in;
    logic we;
    if (g == 0) begin : g_first
      assign tok_in = start_r;
    end else begin : g_rest
      assign tok_in = tok[g-1];
    end
    assign we = cfg_acc && (cfg_index == CFG_IDX_W'(g));
    lsbm_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .idx        (LED_IDX_W'(g)),
      .cmd        (cmd_r),
      .adv        (adv),
      .tok_in     (tok_in),
      .later_in   (later[g+1]),
      .cfg_we     (we),
      .cfg_assign (cfg_data[ASSIGN_W-1:0]),
      .tok_out    (tok[g]),
      .later_out  (later[g]),
      .res        (res[g])
    );
  end

  // Merge the token holder's result; only one cell holds the token
  always_comb begin
    res_any = '0;
    for (int i = 0; i < NUM_LEDS; i++) begin
      res_any = res_any | res[i];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res_any.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_any.valid) begin
      out_data_r.led_index <= res_any.led_index;
      out_data_r.led_state <= res_any.led_state;
      out_data_r.last      <= res_any.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
